// ===== rtl/baro_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types and constants for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

  // Rated output range
  localparam logic signed [20:0] TEMP_MIN = -21'sd4000;
  localparam logic signed [20:0] TEMP_MAX = 21'sd8500;
  localparam logic signed [32:0] PRES_MIN = 33'sd1000;
  localparam logic signed [32:0] PRES_MAX = 33'sd120000;

  // 20.00 degC reference point
  localparam logic signed [19:0] TEMP_REF = 20'sd2000;
  // Very low temperature: TEMP < -15.00 degC means base < -(2000 + 1500)
  localparam logic signed [19:0] VLOW_OFS = 20'sd3500;

  // Calibration register indexes
  typedef enum logic [2:0] {
    REG_SENS_AT_REF        = 3'd0,
    REG_OFFSET_AT_REF      = 3'd1,
    REG_SENS_TEMP_COEFF    = 3'd2,
    REG_OFFSET_TEMP_COEFF  = 3'd3,
    REG_REF_TEMPERATURE    = 3'd4,
    REG_TEMP_COEFF_OF_TEMP = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] sens_at_ref;
    logic [15:0] offset_at_ref;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] ref_temperature;
    logic [15:0] temp_coeff_of_temp;
  } coef_t;

  typedef struct packed {
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
  } raw_t;

  // First-order results
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [18:0] base;   // dT*C6 >> 23
    logic signed [19:0] temp;
    logic signed [41:0] off;
    logic signed [41:0] sens;
    logic        [17:0] t2;
  } first_t;

  // Corrected values, temperature already saturated
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [14:0] temperature;
    logic               t_clamped;
    logic signed [41:0] off;
    logic signed [41:0] sens;
  } corr_t;

  typedef struct packed {
    logic               clamped;
    logic        [16:0] pressure;
    logic signed [14:0] temperature;
  } result_t;

endpackage

// ===== rtl/baro_first.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_first
// First-order compensation: dT, the four products on dT, TEMP, OFF and SENS.
// Three register stages.
// ----------------------------------------------------------------------------
module baro_first (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  baro_pkg::coef_t  coef_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  baro_pkg::raw_t   in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output baro_pkg::first_t out_o
);
  import baro_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic        [23:0] d1_1_q, d1_2_q;
  logic signed [24:0] dt_d, dt_q;
  logic signed [41:0] dtc6_d, dtc6_q, offm_d, offm_q, sensm_d, sensm_q;
  logic signed [49:0] dtsq_d;
  logic        [17:0] t2_q;
  first_t             res_d, res_q;

  // Stage enables: a stage loads when empty or when its successor moves
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: dT = D2 - C5*256
  assign dt_d = $signed({1'b0, in_i.raw_temperature})
              - $signed({1'b0, coef_i.ref_temperature, 8'b0});

  // Stage 2: products on dT
  assign dtc6_d  = dt_q * $signed({1'b0, coef_i.temp_coeff_of_temp});
  assign offm_d  = dt_q * $signed({1'b0, coef_i.offset_temp_coeff});
  assign sensm_d = dt_q * $signed({1'b0, coef_i.sens_temp_coeff});
  assign dtsq_d  = dt_q * dt_q;

  // Stage 3: first-order TEMP, OFF, SENS
  always_comb begin
    res_d      = '0;
    res_d.d1   = d1_2_q;
    res_d.base = dtc6_q[41:23];
    res_d.temp = TEMP_REF + {res_d.base[18], res_d.base};
    res_d.off  = $signed({10'b0, coef_i.offset_at_ref, 16'b0}) + (offm_q >>> 7);
    res_d.sens = $signed({11'b0, coef_i.sens_at_ref, 15'b0}) + (sensm_q >>> 8);
    res_d.t2   = t2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      dt_q   <= dt_d;
      d1_1_q <= in_i.raw_pressure;
    end
    if (en2 && v1_q) begin
      dtc6_q  <= dtc6_d;
      offm_q  <= offm_d;
      sensm_q <= sensm_d;
      t2_q    <= dtsq_d[48:31];
      d1_2_q  <= d1_1_q;
    end
    if (en3 && v2_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/baro_corr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_corr
// Second-order correction for low and very low temperature, then the
// corrected TEMP (saturated), OFF and SENS. Three register stages.
// ----------------------------------------------------------------------------
module baro_corr (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  baro_pkg::first_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output baro_pkg::corr_t  out_o
);
  import baro_pkg::*;

  logic v4_q, v5_q, v6_q;
  logic en4, en5, en6;

  // Stage 4 registers
  logic signed [39:0] sq_d, sq_q, vv_d, vv_q;
  logic signed [19:0] u_d;
  logic               low_q, vlow_q;
  first_t             f_q;

  // Stage 5 registers
  logic signed [41:0] sq_x, vv_x, off2_d, sens2_d, off2_q, sens2_q;
  logic signed [41:0] off5_q, sens5_q;
  logic signed [20:0] tc_d, tc_q;
  logic        [23:0] d1_5_q;

  corr_t              res_d, res_q;

  assign en6 = !v6_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_ready_o  = en4;
  assign out_valid_o = v6_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Stage 4: squares of (TEMP-2000) and (TEMP+1500)
  assign u_d  = {in_i.base[18], in_i.base} + VLOW_OFS;
  assign sq_d = in_i.base * in_i.base;
  assign vv_d = u_d * u_d;

  // Stage 5: OFF2, SENS2 and TEMP - T2
  always_comb begin
    sq_x    = {{2{sq_q[39]}}, sq_q};
    vv_x    = {{2{vv_q[39]}}, vv_q};
    off2_d  = '0;
    sens2_d = '0;
    tc_d    = {f_q.temp[19], f_q.temp};
    if (low_q) begin
      off2_d  = ((sq_x <<< 2) + sq_x) >>> 1;
      sens2_d = ((sq_x <<< 2) + sq_x) >>> 2;
      tc_d    = {f_q.temp[19], f_q.temp} - $signed({3'b0, f_q.t2});
      if (vlow_q) begin
        off2_d  = off2_d + ((vv_x <<< 3) - vv_x);
        sens2_d = sens2_d + (((vv_x <<< 3) + (vv_x <<< 1) + vv_x) >>> 1);
      end
    end
  end

  // Stage 6: corrected OFF/SENS, saturated temperature
  always_comb begin
    res_d      = '0;
    res_d.d1   = d1_5_q;
    res_d.off  = off5_q - off2_q;
    res_d.sens = sens5_q - sens2_q;
    if (tc_q < TEMP_MIN) begin
      res_d.temperature = TEMP_MIN[14:0];
      res_d.t_clamped   = 1'b1;
    end else if (tc_q > TEMP_MAX) begin
      res_d.temperature = TEMP_MAX[14:0];
      res_d.t_clamped   = 1'b1;
    end else begin
      res_d.temperature = tc_q[14:0];
      res_d.t_clamped   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      sq_q   <= sq_d;
      vv_q   <= vv_d;
      low_q  <= in_i.base[18];
      vlow_q <= (u_d < 20'sd0);
      f_q    <= in_i;
    end
    if (en5 && v4_q) begin
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
      tc_q    <= tc_d;
      off5_q  <= f_q.off;
      sens5_q <= f_q.sens;
      d1_5_q  <= f_q.d1;
    end
    if (en6 && v5_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/baro_pres.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pres
// Pressure: D1*SENS split in two partial products, scaling, offset removal
// and saturation. Four register stages, the last one is the output register.
// ----------------------------------------------------------------------------
module baro_pres (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  baro_pkg::corr_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output baro_pkg::result_t out_o
);
  import baro_pkg::*;

  logic v7_q, v8_q, v9_q, v10_q;
  logic en7, en8, en9, en10;

  // Carried along: offset and saturated temperature
  logic signed [41:0] off7_q, off8_q;
  logic signed [14:0] t7_q, t8_q, t9_q;
  logic               tcl7_q, tcl8_q, tcl9_q;

  logic        [44:0] plo_d, plo_q;
  logic signed [45:0] phi_d, phi_q;
  logic signed [46:0] ps_d, ps_q;
  logic signed [47:0] diff_d;
  logic signed [32:0] pres_q;
  result_t            res_d, res_q;

  assign en10 = !v10_q || out_ready_i;
  assign en9  = !v9_q || en10;
  assign en8  = !v8_q || en9;
  assign en7  = !v7_q || en8;
  assign in_ready_o  = en7;
  assign out_valid_o = v10_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      if (en7)  v7_q  <= in_valid_i;
      if (en8)  v8_q  <= v7_q;
      if (en9)  v9_q  <= v8_q;
      if (en10) v10_q <= v9_q;
    end
  end

  // Stage 7: D1 * SENS as low (unsigned) and high (signed) halves of SENS
  assign plo_d = in_i.d1 * in_i.sens[20:0];
  assign phi_d = $signed({1'b0, in_i.d1}) * $signed(in_i.sens[41:21]);

  // Stage 8: floor(D1*SENS / 2^21) = phi + floor(plo / 2^21)
  assign ps_d = {phi_q[45], phi_q} + $signed({23'b0, plo_q[44:21]});

  // Stage 9: subtract OFF, floor by 2^15
  assign diff_d = {ps_q[46], ps_q} - {{6{off8_q[41]}}, off8_q};

  // Stage 10: pressure saturation
  always_comb begin
    res_d             = '0;
    res_d.temperature = t9_q;
    if (pres_q < PRES_MIN) begin
      res_d.pressure = PRES_MIN[16:0];
      res_d.clamped  = 1'b1;
    end else if (pres_q > PRES_MAX) begin
      res_d.pressure = PRES_MAX[16:0];
      res_d.clamped  = 1'b1;
    end else begin
      res_d.pressure = pres_q[16:0];
      res_d.clamped  = tcl9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7 && in_valid_i) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      off7_q <= in_i.off;
      t7_q   <= in_i.temperature;
      tcl7_q <= in_i.t_clamped;
    end
    if (en8 && v7_q) begin
      ps_q   <= ps_d;
      off8_q <= off7_q;
      t8_q   <= t7_q;
      tcl8_q <= tcl7_q;
    end
    if (en9 && v8_q) begin
      pres_q <= diff_d[47:15];
      t9_q   <= t8_q;
      tcl9_q <= tcl8_q;
    end
    if (en10 && v9_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/baro_sensor_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Barometer compensation: raw pressure/temperature conversions in,
// compensated temperature (0.01 degC) and pressure (0.01 mbar) out.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration coefficients through cfg_we_i/cfg_idx_i/
//   cfg_data_i (index 0..5, other indexes ignored) while no transfer is in
//   flight. Raw conversion pairs arrive on the s_axis channel; each one gives
//   exactly one result on the m_axis channel, in order.
//   Throughput: one transfer per cycle; ten register stages (three first
//   order, three second order, four pressure multiply/scale/saturate), each
//   about one multiplier or a short add chain deep.
//   Stall: every stage has its own valid bit and loads when empty or when
//   its successor moves, so bubbles close up and s_axis_tready stays high
//   until all ten stages hold an item while m_axis_tready is low.
//   Reset: clears all valid bits and the coefficients to zero.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Raw input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // temperature[14:0], pressure[31:15]
  output logic [0:0]  m_axis_tuser    // clamped[0]
);
  import baro_pkg::*;

  coef_t   coef_q;
  raw_t    raw;
  first_t  first;
  corr_t   corr;
  result_t res;
  logic    first_valid, first_ready, corr_valid, corr_ready;

  // Calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SENS_AT_REF:        coef_q.sens_at_ref        <= cfg_data_i;
        REG_OFFSET_AT_REF:      coef_q.offset_at_ref      <= cfg_data_i;
        REG_SENS_TEMP_COEFF:    coef_q.sens_temp_coeff    <= cfg_data_i;
        REG_OFFSET_TEMP_COEFF:  coef_q.offset_temp_coeff  <= cfg_data_i;
        REG_REF_TEMPERATURE:    coef_q.ref_temperature    <= cfg_data_i;
        REG_TEMP_COEFF_OF_TEMP: coef_q.temp_coeff_of_temp <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign raw.raw_pressure    = s_axis_tdata[23:0];
  assign raw.raw_temperature = s_axis_tdata[47:24];

  baro_first u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (raw),
    .out_valid_o (first_valid),
    .out_ready_i (first_ready),
    .out_o       (first)
  );

  baro_corr u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (first_valid),
    .in_ready_o  (first_ready),
    .in_i        (first),
    .out_valid_o (corr_valid),
    .out_ready_i (corr_ready),
    .out_o       (corr)
  );

  baro_pres u_pres (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corr_valid),
    .in_ready_o  (corr_ready),
    .in_i        (corr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {res.pressure, res.temperature};
  assign m_axis_tuser = res.clamped;

`ifndef SYNTH
  // Results always lie in the rated range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(res.temperature) >= -15'sd4000 &&
                       $signed(res.temperature) <= 15'sd8500))
    else $error("temperature outside rated range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.pressure >= 17'd1000 && res.pressure <= 17'd120000))
    else $error("pressure outside rated range");

  // An unsaturated result never shows a zero pressure or the most negative temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.clamped) |->
      (res.pressure != 17'd0 && $signed(res.temperature) != -15'sd16384))
    else $error("unflagged result outside range");

  // Nothing leaves the pipeline right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== test/baro_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_checker
// Watches the calibration write port and both streams of the barometer
// compensation block. Computes the expected temperature, pressure and clamp
// flag for every raw pair taken in, then compares each result transfer, in
// order, field by field against the oldest pending reading.
// ----------------------------------------------------------------------------
module baro_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // temperature[14:0], pressure[31:15]
  input  logic [0:0]  m_axis_tuser,   // clamped[0]
  output int          mismatch_count_o,
  output int          pending_o
);

  import baro_pkg::*;

  coef_t   cal;
  result_t pending_readings[$];
  result_t want;

  // Compensated reading from one raw pair, 64-bit signed throughout
  function automatic result_t compensate(coef_t c, logic [23:0] d1_raw,
                                         logic [23:0] d2_raw);
    longint  d1, d2, k1, k2, k3, k4, k5, k6;
    longint  dt, base, temp, off, sens, t2, off2, sens2, sq, v, pres;
    logic    clamp;
    result_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    k1 = c.sens_at_ref;
    k2 = c.offset_at_ref;
    k3 = c.sens_temp_coeff;
    k4 = c.offset_temp_coeff;
    k5 = c.ref_temperature;
    k6 = c.temp_coeff_of_temp;

    // first order
    dt   = d2 - k5 * 256;
    base = (dt * k6) >>> 23;
    temp = 2000 + base;
    off  = k2 * 65536 + ((k4 * dt) >>> 7);
    sens = k1 * 32768 + ((k3 * dt) >>> 8);

    // second order, below 20.00 degC and again below -15.00 degC
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < 2000) begin
      sq    = base * base;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp < -1500) begin
        v     = (temp + 1500) * (temp + 1500);
        off2  = off2 + 7 * v;
        sens2 = sens2 + ((11 * v) >>> 1);
      end
    end
    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    pres = (((d1 * sens) >>> 21) - off) >>> 15;

    // saturate to the rated range
    clamp = 1'b0;
    if (temp < TEMP_MIN) begin temp = TEMP_MIN; clamp = 1'b1; end
    if (temp > TEMP_MAX) begin temp = TEMP_MAX; clamp = 1'b1; end
    if (pres < PRES_MIN) begin pres = PRES_MIN; clamp = 1'b1; end
    if (pres > PRES_MAX) begin pres = PRES_MAX; clamp = 1'b1; end

    r.temperature = temp[14:0];
    r.pressure    = pres[16:0];
    r.clamped     = clamp;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Track calibration writes, check results, queue new readings
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal = '0;
      pending_readings.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SENS_AT_REF:        cal.sens_at_ref        = cfg_data_i;
          REG_OFFSET_AT_REF:      cal.offset_at_ref      = cfg_data_i;
          REG_SENS_TEMP_COEFF:    cal.sens_temp_coeff    = cfg_data_i;
          REG_OFFSET_TEMP_COEFF:  cal.offset_temp_coeff  = cfg_data_i;
          REG_REF_TEMPERATURE:    cal.ref_temperature    = cfg_data_i;
          REG_TEMP_COEFF_OF_TEMP: cal.temp_coeff_of_temp = cfg_data_i;
          default: ;  // spare indexes are ignored
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("result transfer with no reading pending");
        end else begin
          want = pending_readings.pop_front();
          if (m_axis_tdata[14:0] !== want.temperature)
            report_mismatch($sformatf("temperature got %0d expected %0d",
                            $signed(m_axis_tdata[14:0]), want.temperature));
          if (m_axis_tdata[31:15] !== want.pressure)
            report_mismatch($sformatf("pressure got %0d expected %0d",
                            m_axis_tdata[31:15], want.pressure));
          if (m_axis_tuser[0] !== want.clamped)
            report_mismatch($sformatf("clamped got %0b expected %0b",
                            m_axis_tuser[0], want.clamped));
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        pending_readings.push_back(compensate(cal, s_axis_tdata[23:0], s_axis_tdata[47:24]));

      pending_o = pending_readings.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the barometer compensation block: loads several calibration
// sets (reset values, a typical sensor, all ones, mixed extremes, random),
// sends directed raw pairs around the temperature thresholds and the rated
// limits, then random pairs with random gaps and result-side stalls.
// ----------------------------------------------------------------------------
module tb_top;

  import baro_pkg::*;

  localparam int          RESET_CYCLES     = 5;
  localparam int          PIPE_LATENCY     = 10;
  localparam int          WATCHDOG_LIMIT   = 2000;
  localparam int          RANDOM_PER_PHASE = 200;
  localparam logic [2:0]  IDX_SPARE_LO     = 3'd6;
  localparam logic [2:0]  IDX_SPARE_HI     = 3'd7;
  localparam logic [23:0] RAW_MAX          = 24'hFFFFFF;
  // typical raw pair for a sensor near 20 degC and 1000 mbar
  localparam logic [23:0] TYP_D1           = 24'd9085466;
  localparam logic [23:0] TYP_D2           = 24'd8569150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int    mismatch_count;
  int    pending;
  coef_t cal;
  bit    sender_gaps;
  bit    sink_stalls;
  int    stall_left;
  int    sink_roll;
  int    idle_cycles;
  // first-order temperature offsets (0.01 degC) around each threshold
  int    base_points[8] = '{6500, 6501, 0, -1, -3500, -3501, -6000, -20000};

  always #5 clk_i = ~clk_i;

  baro_sensor_compensation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  baro_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Raw temperature whose first-order offset is the smallest dT reaching target
  function automatic logic [23:0] raw_for_base(int target, int jitter);
    longint c6, num, dt, d2;
    c6 = cal.temp_coeff_of_temp;
    if (c6 == 0) return 24'($urandom);
    num = longint'(target) * 8388608;
    dt  = (num >= 0) ? (num + c6 - 1) / c6 : num / c6;
    d2  = cal.ref_temperature;
    d2  = d2 * 256 + dt + jitter;
    if (d2 < 0) d2 = 0;
    if (d2 > 16777215) d2 = 16777215;
    return d2[23:0];
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Write all six coefficients plus one spare index that must be ignored
  task automatic load_coefs(input logic [15:0] c1, c2, c3, c4, c5, c6);
    cal.sens_at_ref        = c1;
    cal.offset_at_ref      = c2;
    cal.sens_temp_coeff    = c3;
    cal.offset_temp_coeff  = c4;
    cal.ref_temperature    = c5;
    cal.temp_coeff_of_temp = c6;
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SENS_AT_REF;
    cfg_data_i <= c1;
    @(negedge clk_i);
    cfg_idx_i  <= REG_OFFSET_AT_REF;
    cfg_data_i <= c2;
    @(negedge clk_i);
    cfg_idx_i  <= REG_SENS_TEMP_COEFF;
    cfg_data_i <= c3;
    @(negedge clk_i);
    cfg_idx_i  <= REG_OFFSET_TEMP_COEFF;
    cfg_data_i <= c4;
    @(negedge clk_i);
    cfg_idx_i  <= REG_REF_TEMPERATURE;
    cfg_data_i <= c5;
    @(negedge clk_i);
    cfg_idx_i  <= REG_TEMP_COEFF_OF_TEMP;
    cfg_data_i <= c6;
    @(negedge clk_i);
    cfg_idx_i  <= ($urandom_range(0, 1) != 0) ? IDX_SPARE_HI : IDX_SPARE_LO;
    cfg_data_i <= 16'($urandom);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One input transfer; returns at the accepting edge
  task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d2, d1};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic sender_pause();
    int n;
    n = sender_gaps ? pick_gap() : 0;
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait until every pending reading has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly temperatures spread over all correction regions, some raw noise
  task automatic send_random();
    logic [23:0] d1, d2;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)       d1 = '0;
    else if (roll < 10) d1 = RAW_MAX;
    else if (roll < 50) d1 = TYP_D1 - 24'd2097152 + 24'($urandom_range(0, 4194303));
    else                d1 = 24'($urandom);
    if ($urandom_range(0, 99) < 70)
      d2 = raw_for_base(int'($urandom_range(0, 14500)) - 8000, int'($urandom_range(0, 400)));
    else
      d2 = 24'($urandom);
    sender_pause();
    send_pair(d1, d2);
  endtask

  // Random pairs with a full drain halfway through
  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      send_random();
    end
    drain();
  endtask

  // Result side: random ready, mostly short stalls with a few long ones
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!sink_stalls) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left    = (sink_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transfer on either stream
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL baro_sensor_compensation");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SENS_AT_REF;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sender_gaps   = 1'b1;
    sink_stalls   = 1'b1;
    cal           = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // coefficients still at their reset value of zero
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair('0, RAW_MAX);
    send_pair(RAW_MAX, '0);
    drain();

    // typical sensor: thresholds, rated limits, raw extremes
    load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_pair(TYP_D1, TYP_D2);
    foreach (base_points[i]) send_pair(TYP_D1, raw_for_base(base_points[i], 0));
    send_pair('0, raw_for_base(0, 0));
    send_pair(RAW_MAX, raw_for_base(0, 0));
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    random_phase(RANDOM_PER_PHASE);

    // all coefficients at maximum
    load_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    random_phase(RANDOM_PER_PHASE);

    // mixed extremes
    load_coefs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    random_phase(RANDOM_PER_PHASE);
    load_coefs(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    random_phase(RANDOM_PER_PHASE);

    // random calibration, gaps and stalls on both sides
    load_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
    random_phase(RANDOM_PER_PHASE);

    // back to back with no idling at all
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    load_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
    random_phase(RANDOM_PER_PHASE);

    // sender never idles while the result side stalls: fills the pipeline
    sink_stalls = 1'b1;
    load_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
    random_phase(RANDOM_PER_PHASE);

    // let any stray result show up before the verdict
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0)
      $display("PASS baro_sensor_compensation");
    else
      $display("FAIL baro_sensor_compensation");
    $finish;
  end

endmodule
